FILE: sv/assert_macros.svh
// Assertion helpers for the RTL; drs_queue.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define DRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/drs_pkg.sv
`timescale 1ns / 1ps
package drs_pkg;

  localparam int SAMPLE_BITS_DEF = 32;
  localparam int MAX_ORDER_DEF   = 8;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CFG_W   = 4;
  localparam int ORD_W   = 2;   // tap count minus one, four orders at most
  localparam int WGT_W   = 14;  // Q13 weights with sign
  localparam int CTR_SHF = 13;  // centre weight is one in Q13
  localparam int OUT_SHF = 14;  // Q13 scale plus the outer half

  localparam logic [CFG_W-1:0] ORDER_RESET = 4'd8;
  localparam logic [CFG_W-1:0] CFG_ORDER2  = 4'd2;
  localparam logic [CFG_W-1:0] CFG_ORDER4  = 4'd4;
  localparam logic [CFG_W-1:0] CFG_ORDER6  = 4'd6;

  localparam logic [ORD_W-1:0] ORD_2 = 2'd0;
  localparam logic [ORD_W-1:0] ORD_4 = 2'd1;
  localparam logic [ORD_W-1:0] ORD_6 = 2'd2;
  localparam logic [ORD_W-1:0] ORD_8 = 2'd3;

  // Odd-offset pair weights, row per order, column per pair.
  localparam logic signed [WGT_W-1:0] W_TAB [4][4] = '{
    '{14'sd4096,     14'sd0,    14'sd0,   14'sd0},
    '{14'sd4608,  -14'sd512,    14'sd0,   14'sd0},
    '{14'sd4800,  -14'sd800,   14'sd96,   14'sd0},
    '{14'sd4900,  -14'sd980,  14'sd196, -14'sd20}
  };

  typedef struct packed {
    logic [ORD_W-1:0] ord;
    logic             last;
  } drs_ctrl_t;

  // Map the register to an order code, lowered to what the build supports.
  function automatic logic [ORD_W-1:0] order_code(logic [CFG_W-1:0] cfg, int max_taps);
    logic [ORD_W-1:0] code;
    case (cfg)
      CFG_ORDER2: code = ORD_2;
      CFG_ORDER4: code = ORD_4;
      CFG_ORDER6: code = ORD_6;
      default:    code = ORD_8;
    endcase
    if (int'(code) > max_taps - 1) code = ORD_W'(max_taps - 1);
    return code;
  endfunction

endpackage

FILE: sv/decimating_restriction_stencil_top.sv
`timescale 1ns / 1ps
// A queued result passes the product, sum and output registers in that order.
// Throughput: one item per cycle while in_ready is high; the front window takes one
// accepted sample per cycle, and the three-stage multiply/add/clamp pipeline takes one
// queued result per cycle while the output is not stalled. Output stalls back up into a
// four-entry queue; in_ready drops only when it is full. Reset (async, active low) clears
// the window, warm-up count, parity, queue and valids, and sets the order register to 8.
module decimating_restriction_stencil_top #(
  parameter int SAMPLE_BITS = drs_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_ORDER   = drs_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [drs_pkg::CFG_W-1:0]    stencil_order_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       sample_value_i,
  input  logic                         row_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [SAMPLE_BITS-1:0]       coarse_value_o,
  output logic                         row_last_o
);
  import drs_pkg::*;

  localparam int MAX_TAPS = MAX_ORDER / 2;
  localparam int PAIRS_W  = MAX_TAPS * (SAMPLE_BITS + 1);
  localparam int ENTRY_W  = $bits(drs_ctrl_t) + PAIRS_W + SAMPLE_BITS;

  logic                                 queue_full, queue_valid, push, pop;
  drs_ctrl_t                            push_ctrl, q_ctrl;
  logic [SAMPLE_BITS-1:0]               push_center, q_center;
  logic [MAX_TAPS-1:0][SAMPLE_BITS:0]   push_pair, q_pair;
  logic [ENTRY_W-1:0]                   q_din, q_dout;

  assign cfg_ready_o = 1'b1;

  drs_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_ORDER   (MAX_ORDER)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .stencil_order_i (stencil_order_i),
    .in_valid_i      (in_valid_i),
    .queue_full_i    (queue_full),
    .in_ready_o      (in_ready_o),
    .sample_value_i  (sample_value_i),
    .row_end_i       (row_end_i),
    .push_o          (push),
    .push_ctrl_o     (push_ctrl),
    .center_o        (push_center),
    .pair_o          (push_pair)
  );

  assign q_din = {push_ctrl, push_pair, push_center};

  drs_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (q_din),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .dout_o  (q_dout)
  );

  assign {q_ctrl, q_pair, q_center} = q_dout;

  drs_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_ORDER   (MAX_ORDER)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (queue_valid),
    .pop_o          (pop),
    .q_ctrl_i       (q_ctrl),
    .q_center_i     (q_center),
    .q_pair_i       (q_pair),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coarse_value_o (coarse_value_o),
    .row_last_o     (row_last_o)
  );

endmodule

FILE: sv/drs_front.sv
`timescale 1ns / 1ps
module drs_front #(
  parameter int SAMPLE_BITS = drs_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_ORDER   = drs_pkg::MAX_ORDER_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [drs_pkg::CFG_W-1:0]              stencil_order_i,
  input  logic                                   in_valid_i,
  input  logic                                   queue_full_i,
  output logic                                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                 sample_value_i,
  input  logic                                   row_end_i,
  output logic                                   push_o,
  output drs_pkg::drs_ctrl_t                     push_ctrl_o,
  output logic [SAMPLE_BITS-1:0]                 center_o,
  output logic [MAX_ORDER/2-1:0][SAMPLE_BITS:0]  pair_o
);
  import drs_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_ORDER - 1;
  localparam int MAX_TAPS  = MAX_ORDER / 2;

  logic signed [SAMPLE_BITS-1:0] win_q [WIN_DEPTH];
  logic signed [SAMPLE_BITS-1:0] win_sh [WIN_DEPTH];
  logic [3:0]                    fill_q;
  logic                          phase_q;
  logic [CFG_W-1:0]              cfg_q;
  logic [ORD_W-1:0]              ord;
  logic [3:0]                    warm;
  logic                          warm_done;
  logic                          accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ord        = order_code(cfg_q, MAX_TAPS);
  assign warm       = {ord, 2'b10};
  assign warm_done  = fill_q >= warm;
  assign push_o     = accept && warm_done && !phase_q;

  assign push_ctrl_o.ord  = ord;
  assign push_ctrl_o.last = row_end_i;

  always_comb begin
    win_sh[0] = sample_value_i;
    for (int j = 1; j < WIN_DEPTH; j++) begin
      win_sh[j] = win_q[j-1];
    end
  end

  // Fold symmetric pairs around the centre of the current order.
  always_comb begin
    center_o = '0;
    pair_o   = '0;
    for (int o = 0; o < MAX_TAPS; o++) begin
      if (ord == ORD_W'(o)) begin
        center_o = win_sh[2*o+1];
        for (int t = 0; t <= o; t++) begin
          pair_o[t] = (SAMPLE_BITS+1)'(win_sh[2*o+2+2*t])
                    + (SAMPLE_BITS+1)'(win_sh[2*o-2*t]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ORDER_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= stencil_order_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      phase_q <= 1'b0;
      for (int j = 0; j < WIN_DEPTH; j++) win_q[j] <= '0;
    end else if (accept) begin
      if (row_end_i) begin
        // drop the line state after its last item
        fill_q  <= '0;
        phase_q <= 1'b0;
        for (int j = 0; j < WIN_DEPTH; j++) win_q[j] <= '0;
      end else begin
        for (int j = 0; j < WIN_DEPTH; j++) win_q[j] <= win_sh[j];
        if (!warm_done) begin
          fill_q <= fill_q + 4'd1;
        end else begin
          phase_q <= !phase_q;
        end
      end
    end
  end

endmodule

FILE: sv/drs_queue.sv
`timescale 1ns / 1ps
module drs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = drs_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] dout_o
);
  import drs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`include "assert_macros.svh"
  `DRS_ASSERT(a_no_overflow, push_i |-> (!full_o || pop_i), "push into a full queue")
  `DRS_ASSERT(a_no_underflow, pop_i |-> valid_o, "pop from an empty queue")
  `DRS_ASSERT(a_cnt_step, (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1, "queue count slipped")

endmodule

FILE: sv/drs_back.sv
`timescale 1ns / 1ps
module drs_back #(
  parameter int SAMPLE_BITS = drs_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_ORDER   = drs_pkg::MAX_ORDER_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  output logic                                   pop_o,
  input  drs_pkg::drs_ctrl_t                     q_ctrl_i,
  input  logic [SAMPLE_BITS-1:0]                 q_center_i,
  input  logic [MAX_ORDER/2-1:0][SAMPLE_BITS:0]  q_pair_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]                 coarse_value_o,
  output logic                                   row_last_o
);
  import drs_pkg::*;

  localparam int MAX_TAPS = MAX_ORDER / 2;
  localparam int PROD_W   = SAMPLE_BITS + 1 + WGT_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int RES_W    = ACC_W - OUT_SHF;

  logic                          adv;
  logic                          v1_q, v2_q, out_valid_q;
  logic                          last1_q, last2_q, out_last_q;
  logic signed [SAMPLE_BITS-1:0] center1_q;
  logic signed [PROD_W-1:0]      prod1_q [MAX_TAPS];
  logic signed [PROD_W-1:0]      prod1_d [MAX_TAPS];
  logic signed [ACC_W-1:0]       acc2_q, acc2_d;
  logic signed [RES_W-1:0]       res;
  logic [SAMPLE_BITS-1:0]        sat;
  logic [SAMPLE_BITS-1:0]        coarse_q;

  // Whole pipeline advances together whenever the output register frees.
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && q_valid_i;

  always_comb begin
    for (int t = 0; t < MAX_TAPS; t++) begin
      prod1_d[t] = $signed(q_pair_i[t]) * W_TAB[q_ctrl_i.ord][2'(t)];
    end
  end

  always_comb begin
    acc2_d = (ACC_W'(center1_q) <<< CTR_SHF) + ACC_W'(1 <<< (OUT_SHF - 1));
    for (int t = 0; t < MAX_TAPS; t++) begin
      acc2_d = acc2_d + ACC_W'(prod1_q[t]);
    end
  end

  // Floor shift, then clamp to the sample range.
  always_comb begin
    res = acc2_q[ACC_W-1:OUT_SHF];
    if (res[RES_W-1:SAMPLE_BITS-1] == '0 || res[RES_W-1:SAMPLE_BITS-1] == '1) begin
      sat = res[SAMPLE_BITS-1:0];
    end else if (res[RES_W-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      center1_q <= q_center_i;
      last1_q   <= q_ctrl_i.last;
      for (int t = 0; t < MAX_TAPS; t++) prod1_q[t] <= prod1_d[t];
      acc2_q     <= acc2_d;
      last2_q    <= last1_q;
      coarse_q   <= sat;
      out_last_q <= last2_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coarse_value_o = coarse_q;
  assign row_last_o     = out_last_q;

endmodule

FILE: tb/tb_decimating_restriction_stencil_top.sv
`timescale 1ns / 1ps
import drs_pkg::*;

typedef struct {
  logic [SAMPLE_BITS_DEF-1:0] value;
  logic                       last;
} coarse_item_t;

class restriction_scoreboard;
  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int MAX_K = MAX_ORDER_DEF;
  localparam int WIN   = 2 * MAX_K - 1;

  longint           fine_window [WIN];
  longint           pair_wgt    [4][4];
  int               fill;
  bit               parity;
  logic [CFG_W-1:0] order_reg;
  coarse_item_t     coarse_due [$];
  int               mismatches;

  function new();
    pair_wgt   = '{'{4096, 0, 0, 0}, '{4608, -512, 0, 0},
                   '{4800, -800, 96, 0}, '{4900, -980, 196, -20}};
    order_reg  = ORDER_RESET;
    mismatches = 0;
    clear_line();
  endfunction

  static function int order_of(logic [CFG_W-1:0] cfg);
    int k;
    case (cfg)
      CFG_ORDER2: k = 2;
      CFG_ORDER4: k = 4;
      CFG_ORDER6: k = 6;
      default:    k = 8;
    endcase
    while (k > MAX_K && k > 2) k -= 2;
    return k;
  endfunction

  function void clear_line();
    foreach (fine_window[i]) fine_window[i] = 0;
    fill   = 0;
    parity = 1'b0;
  endfunction

  function void set_order(logic [CFG_W-1:0] v);
    order_reg = v;
  endfunction

  function int pending();
    return coarse_due.size();
  endfunction

  // Centre times one plus weighted odd-offset pairs, then round half up and clamp.
  function longint restrict_center(int k);
    longint acc, hi, lo;
    int     c;
    c   = k - 1;
    acc = (longint'(1) <<< CTR_SHF) * fine_window[c];
    for (int t = 0; t < k / 2; t++)
      acc += pair_wgt[k/2-1][t] * (fine_window[c+2*t+1] + fine_window[c-2*t-1]);
    acc = (acc + (longint'(1) <<< (OUT_SHF - 1))) >>> OUT_SHF;
    hi  = (longint'(1) <<< (SB - 1)) - 1;
    lo  = -hi - 1;
    if (acc > hi) acc = hi;
    if (acc < lo) acc = lo;
    return acc;
  endfunction

  function void take_fine_sample(logic [SB-1:0] s, logic e);
    int           k;
    coarse_item_t x;
    k = order_of(order_reg);
    for (int i = WIN - 1; i > 0; i--) fine_window[i] = fine_window[i-1];
    fine_window[0] = longint'($signed(s));
    if (fill < 2 * k - 2) begin
      fill++;
    end else begin
      if (!parity) begin
        x.value = SB'(restrict_center(k));
        x.last  = e;
        coarse_due.push_back(x);
      end
      parity = ~parity;
    end
    if (e) clear_line();
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task check_coarse(logic [SB-1:0] v, logic l);
    coarse_item_t x;
    if (coarse_due.size() == 0) begin
      report_mismatch($sformatf("result %0d with none outstanding", $signed(v)));
      return;
    end
    x = coarse_due.pop_front();
    if (v !== x.value)
      report_mismatch($sformatf("coarse_value %0d, want %0d", $signed(v), $signed(x.value)));
    if (l !== x.last)
      report_mismatch($sformatf("row_last %0b, want %0b", l, x.last));
  endtask
endclass

module tb_decimating_restriction_stencil_top;
  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int PIPE_CYCLES = 8;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 90;
  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] stencil_order_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [SB-1:0]    sample_value_i;
  logic             row_end_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [SB-1:0]    coarse_value_o;
  logic             row_last_o;

  restriction_scoreboard sb = new();
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;
  int line_left;

  logic [CFG_W-1:0] order_plan [PHASES] = '{4'd0, CFG_ORDER6, 4'd15, CFG_ORDER2,
                                            CFG_ORDER4, ORDER_RESET, 4'd3, CFG_ORDER6,
                                            4'd9, CFG_ORDER2, CFG_ORDER4, ORDER_RESET};

  decimating_restriction_stencil_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .stencil_order_i(stencil_order_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .row_end_i      (row_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coarse_value_o (coarse_value_o),
    .row_last_o     (row_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_order(stencil_order_i);
      if (in_valid_i && in_ready_o) sb.take_fine_sample(sample_value_i, row_end_i);
      if (out_valid_o && out_ready_i) sb.check_coarse(coarse_value_o, row_last_o);
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("decimating_restriction_stencil_top verification failed");
    $finish;
  end

  // Order 8: weights that add go to the maximum, weights that subtract to the minimum.
  function automatic logic [SB-1:0] order8_peak(int idx);
    case (idx)
      2, 6, 7, 8, 12: return S_MAX;
      0, 4, 10, 14:   return S_MIN;
      default:        return '0;
    endcase
  endfunction

  function automatic logic [SB-1:0] order4_trough(int idx);
    case (idx)
      2, 3, 4: return S_MIN;
      0, 6:    return S_MAX;
      default: return '0;
    endcase
  endfunction

  function automatic logic [SB-1:0] random_sample();
    case ($urandom_range(7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SB'(int'($urandom_range(8)) - 4);
      default: return SB'($urandom());
    endcase
  endfunction

  task automatic send_item(logic [SB-1:0] s, logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= s;
    row_end_i      <= e;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lines mostly have a length that yields whole outputs; the rest are short or odd.
  task automatic send_random_item(logic [CFG_W-1:0] cfg);
    int k;
    k = sb.order_of(cfg);
    if (line_left == 0) begin
      if ($urandom_range(9) < 8) line_left = 2 * int'($urandom_range(1, 6)) + 2 * k - 3;
      else line_left = int'($urandom_range(1, 2 * k + 4));
    end
    send_item(random_sample(), line_left == 1);
    line_left--;
  endtask

  task automatic write_order(logic [CFG_W-1:0] v);
    cfg_valid_i     <= 1'b1;
    stencil_order_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    stencil_order_i = ORDER_RESET;
    in_valid_i      = 1'b0;
    sample_value_i  = '0;
    row_end_i       = 1'b0;
    src_idle_pct    = 23;
    snk_idle_pct    = 61;
    hold_left       = 0;
    line_left       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Positive saturation at the reset order, then a line too short to produce.
    for (int j = 0; j < 15; j++) send_item(order8_peak(14 - j), j == 14);
    send_item(S_MAX, 1'b0);
    send_item(S_MIN, 1'b1);

    settle_idle();
    write_order(CFG_ORDER4);
    for (int j = 0; j < 7; j++) send_item(order4_trough(6 - j), j == 6);

    // Order 2: a positive half rounds up, a negative half rounds up to zero.
    settle_idle();
    write_order(CFG_ORDER2);
    send_item('0, 1'b0);
    send_item(SB'(1), 1'b0);
    send_item('0, 1'b0);
    send_item({SB{1'b1}}, 1'b0);
    send_item('0, 1'b1);

    // Lines run across phases, so some order changes land mid-line.
    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct = (p < 4) ? 23 : ((p < 8) ? 61 : 0);
      snk_idle_pct = (p < 4) ? 61 : ((p < 8) ? 23 : 0);
      settle_idle();
      write_order(order_plan[p]);
      if (p == 2) hold_left = 80;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
        send_random_item(order_plan[p]);
      end
    end

    settle_idle();
    if (sb.mismatches == 0) begin
      $display("decimating_restriction_stencil_top verification clean");
    end else begin
      $display("decimating_restriction_stencil_top verification failed");
    end
    $finish;
  end
endmodule
